FILE: rtl/core/bss_pkg.sv
// bss_pkg: shared codes and control structs for the bounded set store
// used by bss_ctrl, bss_datapath and bounded_set_store_unit; no dependencies
package bss_pkg;

    // request kinds
    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_DUP     = 2'd2;
    localparam logic [1:0] STATUS_MISSING = 2'd3;

    // field widths
    localparam int ELEM_W  = 32;
    localparam int KIND_W  = 2;
    localparam int OCNT_W  = 7;

    // controller to datapath
    typedef struct packed {
        logic start;   // latch a new request, rewind the scan
        logic scan;    // search pass over the store
        logic shift;   // close the gap after a removed entry
        logic commit;  // update count, append on add, load result
    } bss_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hit;        // read entry matches the request value
        logic drained;    // no read in flight and no entry left to read
        logic is_remove;  // current request is a remove
    } bss_stat_t;

endpackage

FILE: rtl/core/bss_datapath.sv
// bss_datapath: value memory, fill count, scan/shift read pipeline, result register
// depends on bss_pkg
module bss_datapath #(
    parameter int CAPACITY = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bss_pkg::bss_cmd_t                 cmd,
    output bss_pkg::bss_stat_t                stat,
    input  logic [bss_pkg::KIND_W-1:0]        in_kind,
    input  logic signed [bss_pkg::ELEM_W-1:0] in_element,
    output logic                              res_present,
    output logic [1:0]                        res_status,
    output logic [bss_pkg::OCNT_W-1:0]        res_count
);
    import bss_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // value memory
    logic [ELEM_W-1:0] mem [CAPACITY];

    logic [KIND_W-1:0]        kind_reg;
    logic signed [ELEM_W-1:0] elem_reg;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         issue_reg, issue_next;
    logic [CNT_W-1:0]         rd_idx_reg, rd_idx_next;
    logic                     rd_vld_reg, rd_vld_next;
    logic                     found_reg, found_next;
    logic [ELEM_W-1:0]        rdata_reg;

    logic                     pres_reg;
    logic [1:0]               status_reg, status_next;
    logic [OCNT_W-1:0]        ocount_reg;

    logic                     re, we;
    logic [IDX_W-1:0]         raddr, waddr;
    logic [ELEM_W-1:0]        wdata;
    logic [CNT_W-1:0]         rd_idx_dec;
    logic [CNT_W+OCNT_W-1:0]  count_wide;

    assign rd_idx_dec = rd_idx_reg - CNT_W'(1);
    assign raddr      = issue_reg[IDX_W-1:0];

    // status toward the controller
    always_comb
    begin
        stat.hit       = rd_vld_reg && (rdata_reg == elem_reg);
        stat.drained   = !rd_vld_reg && (issue_reg >= count_reg);
        stat.is_remove = (kind_reg == KIND_REMOVE);
    end

    // read pipeline shared by the search and the shift pass
    always_comb
    begin
        issue_next  = issue_reg;
        rd_idx_next = rd_idx_reg;
        rd_vld_next = rd_vld_reg;
        found_next  = found_reg;
        re          = 1'b0;
        if (cmd.start)
        begin
            issue_next  = '0;
            rd_vld_next = 1'b0;
            found_next  = 1'b0;
        end
        else if (cmd.scan && stat.hit)
        begin
            // resume reading just past the match for the shift pass
            issue_next  = rd_idx_reg + CNT_W'(1);
            rd_vld_next = 1'b0;
            found_next  = 1'b1;
        end
        else if (cmd.scan || cmd.shift)
        begin
            if (issue_reg < count_reg)
            begin
                re          = 1'b1;
                rd_vld_next = 1'b1;
                rd_idx_next = issue_reg;
                issue_next  = issue_reg + CNT_W'(1);
            end
            else
            begin
                rd_vld_next = 1'b0;
            end
        end
    end

    // commit: status, count update and append; shift-pass write of the moved entry
    always_comb
    begin
        count_next  = count_reg;
        status_next = STATUS_DONE;
        we          = 1'b0;
        waddr       = rd_idx_dec[IDX_W-1:0];
        wdata       = rdata_reg;
        if (cmd.shift && rd_vld_reg)
        begin
            // move entry down by one
            we = 1'b1;
        end
        if (cmd.commit)
        begin
            case (kind_reg)
                KIND_ADD:
                begin
                    if (found_reg)
                    begin
                        status_next = STATUS_DUP;
                    end
                    else if (count_reg >= CNT_W'(CAPACITY))
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        we         = 1'b1;
                        waddr      = count_reg[IDX_W-1:0];
                        wdata      = elem_reg;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                KIND_REMOVE:
                begin
                    if (found_reg)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    else
                    begin
                        status_next = STATUS_MISSING;
                    end
                end
                default:
                begin
                    status_next = STATUS_DONE;
                end
            endcase
        end
    end

    assign count_wide = {{OCNT_W{1'b0}}, count_next};

    // memory ports
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            rd_vld_reg <= 1'b0;
            issue_reg  <= '0;
            found_reg  <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            rd_vld_reg <= rd_vld_next;
            issue_reg  <= issue_next;
            found_reg  <= found_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_idx_next;
        if (cmd.start)
        begin
            kind_reg <= in_kind;
            elem_reg <= in_element;
        end
        if (cmd.commit)
        begin
            pres_reg   <= found_reg;
            status_reg <= status_next;
            ocount_reg <= count_wide[OCNT_W-1:0];
        end
    end

    assign res_present = pres_reg;
    assign res_status  = status_reg;
    assign res_count   = ocount_reg;

endmodule

FILE: rtl/core/bss_ctrl.sv
// bss_ctrl: request sequencer for the bounded set store, owns both handshakes
// depends on bss_pkg
module bss_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  bss_pkg::bss_stat_t stat,
    output bss_pkg::bss_cmd_t  cmd
);
    import bss_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_SHIFT  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       ovalid_reg, ovalid_next;
    logic       out_free;

    assign out_free = !ovalid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.hit)
                begin
                    state_next = stat.is_remove ? S_SHIFT : S_FINISH;
                end
                else if (stat.drained)
                begin
                    state_next = S_FINISH;
                end
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (stat.drained)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result valid flag
    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (cmd.commit)
        begin
            ovalid_next = 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid = ovalid_reg;

endmodule

FILE: rtl/core/bounded_set_store_unit.sv
// bounded_set_store_unit: top level of the bounded set store
// depends on bss_pkg, bss_ctrl and bss_datapath
//
//  channel | dir | signals                    | contents
//  s_      | in  | tvalid tready tdata tuser  | request: kind, element
//  m_      | out | tvalid tready tdata        | result: present, status, count
//
// an item takes longer the larger N, the count held: the search reads one entry per cycle
// through the single read port of the value memory, and a remove that finds its value
// below the last entry then moves each later entry down one per cycle over the same port
// reset clears the count and the handshakes; the memory holds no reset state
// a new item is taken while the previous result waits in the output register;
// a stalled output holds the next item at its final step
module bounded_set_store_unit #(
    parameter int CAPACITY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] element
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [0] present, [2:1] status, [9:3] count, [15:10] zero
);
    import bss_pkg::*;

    bss_cmd_t          cmd;
    bss_stat_t         stat;
    logic              res_present;
    logic [1:0]        res_status;
    logic [OCNT_W-1:0] res_count;

    bss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bss_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_kind     (s_tuser),
        .in_element  (s_tdata),
        .res_present (res_present),
        .res_status  (res_status),
        .res_count   (res_count)
    );

    // pack the result item
    assign m_tdata = {6'b0, res_count, res_status, res_present};

endmodule

FILE: test/tb_bounded_set_store_unit.sv
// tb_bounded_set_store_unit: self-checking testbench for the bounded set store
// depends on bss_pkg and bounded_set_store_unit; predicts every result from its own set copy

module tb_bounded_set_store_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import bss_pkg::*;

    localparam int CAPACITY      = 64;
    localparam int HOLD_CYCLES   = 600;
    localparam int STALL_LIMIT   = 4000;
    localparam int POOL_N        = 96;
    localparam int RANDOM_ITEMS  = 880;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // one result item as the block reports it
    typedef struct packed {
        logic       present;
        logic [1:0] status;
        logic [6:0] count;
    } set_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // [31:0] element
    logic [1:0]  s_tuser = '0;   // [1:0] kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // [0] present, [2:1] status, [9:3] count, [15:10] zero

    // predictor state: values held, in store order
    logic [31:0] held_values[$];
    set_result_t awaited_results[$];
    logic [31:0] value_pool[POOL_N];

    int  mismatch_count = 0;
    int  stall_cycles = 0;
    bit  burst_mode = 1'b0;
    bit  hold_out_req = 1'b0;

    bounded_set_store_unit #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // idle cycles before the next item on either side
    function automatic int draw_gap();
        if (burst_mode || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 18);
    endfunction

    // shared value pool with the extremes in front
    function automatic void fill_value_pool();
        foreach (value_pool[i])
            value_pool[i] = $urandom;
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
    endfunction

    // set behavior: look up, then add, remove or just report
    function automatic set_result_t predict_set_result(input logic [1:0] kind,
                                                       input logic [31:0] elem);
        set_result_t res;
        int          slot;
        slot = -1;
        foreach (held_values[i])
            if (slot < 0 && held_values[i] == elem)
                slot = i;
        res.present = (slot >= 0);
        res.status  = STATUS_DONE;
        if (kind == KIND_ADD)
        begin
            if (slot >= 0)
                res.status = STATUS_DUP;
            else if (held_values.size() >= CAPACITY)
                res.status = STATUS_FULL;
            else
                held_values.push_back(elem);
        end
        else if (kind == KIND_REMOVE)
        begin
            if (slot >= 0)
                held_values.delete(slot);
            else
                res.status = STATUS_MISSING;
        end
        res.count = 7'(held_values.size());
        return res;
    endfunction

    // offer one request item and wait until it is taken
    task automatic send_request(input logic [1:0] kind, input logic [31:0] elem);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= elem;
        awaited_results.push_back(predict_set_result(kind, elem));
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    // one request with a kind mix and values mostly from the shared pool
    task automatic send_random_request(input int add_pct, input int remove_pct);
        int          r;
        logic [1:0]  kind;
        logic [31:0] elem;
        r = $urandom_range(0, 99);
        if (r < 3)
            kind = KIND_UNUSED;
        else if (r < 3 + add_pct)
            kind = KIND_ADD;
        else if (r < 3 + add_pct + remove_pct)
            kind = KIND_REMOVE;
        else
            kind = KIND_QUERY;
        // removes mostly aim at held values so the shift path is busy
        if (kind == KIND_REMOVE && held_values.size() != 0 && $urandom_range(0, 3) != 0)
            elem = held_values[$urandom_range(0, held_values.size() - 1)];
        else if ($urandom_range(0, 7) == 0)
            elem = $urandom;
        else
            elem = value_pool[$urandom_range(0, POOL_N - 1)];
        send_request(kind, elem);
    endtask

    // extremes, every kind, duplicates, misses, removes at head, middle and tail
    task automatic test_directed();
        send_request(KIND_ADD, 32'h8000_0000);
        send_request(KIND_ADD, 32'h7FFF_FFFF);
        send_request(KIND_ADD, 32'h0000_0000);
        send_request(KIND_ADD, 32'hFFFF_FFFF);
        send_request(KIND_ADD, 32'h7FFF_FFFF);
        send_request(KIND_QUERY, 32'h0000_0000);
        send_request(KIND_QUERY, 32'h0000_0001);
        send_request(KIND_UNUSED, 32'hFFFF_FFFF);
        send_request(KIND_UNUSED, 32'h0000_0005);
        send_request(KIND_REMOVE, 32'h7FFF_FFFF);
        send_request(KIND_REMOVE, 32'h7FFF_FFFF);
        send_request(KIND_QUERY, 32'h7FFF_FFFF);
        send_request(KIND_REMOVE, 32'hFFFF_FFFF);
        send_request(KIND_REMOVE, 32'h8000_0000);
        send_request(KIND_REMOVE, 32'h0000_0000);
        send_request(KIND_REMOVE, 32'h0000_0000);
        send_request(KIND_QUERY, 32'h0000_0000);
        send_request(KIND_ADD, 32'h5555_5555);
        send_request(KIND_ADD, 32'hAAAA_AAAA);
        wait_results_drained();
    endtask

    // fill to capacity, reject when full, duplicate into a full store, then empty it
    task automatic test_fill_capacity();
        int          idx;
        logic [31:0] elem;
        idx = 0;
        burst_mode = 1'b1;
        while (held_values.size() < CAPACITY)
        begin
            send_request(KIND_ADD, 32'h1000_0000 + idx);
            idx++;
        end
        burst_mode = 1'b0;
        send_request(KIND_ADD, 32'h2000_0000);
        send_request(KIND_ADD, 32'h5555_5555);
        send_request(KIND_QUERY, held_values[CAPACITY - 1]);
        send_request(KIND_REMOVE, held_values[0]);
        send_request(KIND_ADD, 32'h2000_0000);
        send_request(KIND_REMOVE, held_values[CAPACITY - 1]);
        while (held_values.size() != 0)
        begin
            elem = held_values[$urandom_range(0, held_values.size() - 1)];
            send_request(KIND_REMOVE, elem);
        end
        wait_results_drained();
    endtask

    // receiver holds off a long stretch while requests keep coming
    task automatic test_backpressure();
        hold_out_req = 1'b1;
        repeat (40)
            send_random_request(60, 20);
        wait_results_drained();
    endtask

    // long random mix, alternating between filling and draining the set
    task automatic test_random_mix();
        int n;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            // stretches with no idle cycles on either side
            burst_mode = (n % 300) >= 220;
            // sender pauses until every result is back
            if (n % 150 == 149)
                wait_results_drained();
            if ((n / 100) % 2 == 0)
                send_random_request(70, 10);
            else
                send_random_request(15, 60);
        end
        burst_mode = 1'b0;
    endtask

    // result receiver with random gaps and one long hold-off on request
    initial
    begin
        int gap;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_out_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_out_req = 1'b0;
            end
            gap = draw_gap();
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
        end
    end

    // compare each taken result with the oldest prediction
    always @(posedge clk)
    begin
        set_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (awaited_results.size() == 0)
            begin
                $display("%0t: result with none awaited, expected none actual %h",
                         $time, m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (m_tdata[0] !== want.present)
                begin
                    $display("%0t: present expected %0d actual %0d",
                             $time, want.present, m_tdata[0]);
                    mismatch_count++;
                end
                if (m_tdata[2:1] !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_tdata[2:1]);
                    mismatch_count++;
                end
                if (m_tdata[9:3] !== want.count)
                begin
                    $display("%0t: count expected %0d actual %0d",
                             $time, want.count, m_tdata[9:3]);
                    mismatch_count++;
                end
                if (m_tdata[15:10] !== 6'd0)
                begin
                    $display("%0t: pad bits expected 0 actual %h", $time, m_tdata[15:10]);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles", $time, stall_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // reset, run the tests in turn, then report
    initial
    begin
        fill_value_pool();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_fill_capacity();
        test_backpressure();
        test_random_mix();
        wait_results_drained();
        repeat (2 * CAPACITY + 20) @(posedge clk);
        if (awaited_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, awaited_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
